// File: hdl/bdq_pkg.sv
package bdq_pkg;

    localparam int DEPTH_DEF      = 64;
    localparam int DATA_WIDTH_DEF = 32;

    localparam int CMD_W    = 3;
    localparam int STATUS_W = 2;

    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_DROP_FRONT = 3'd2;
    localparam logic [CMD_W-1:0] CMD_DROP_BACK  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_DUMP       = 3'd4;

    localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;

    // Work passed from the front end to the back end.
    typedef enum logic [1:0] {
        OP_WRITE  = 2'd0,
        OP_STATUS = 2'd1,
        OP_DUMP   = 2'd2
    } op_kind_t;

    typedef struct packed {
        op_kind_t            kind;
        logic [STATUS_W-1:0] status;
    } op_ctrl_t;

    typedef struct packed {
        logic                dump;
        logic                last;
        logic [STATUS_W-1:0] status;
    } res_meta_t;

endpackage

// File: hdl/bdq_ram.sv
module bdq_ram #(
    parameter int WIDTH = bdq_pkg::DATA_WIDTH_DEF,
    parameter int DEPTH = bdq_pkg::DEPTH_DEF
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hdl/bdq_front.sv
module bdq_front #(
    parameter int DEPTH      = bdq_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = bdq_pkg::DATA_WIDTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [bdq_pkg::CMD_W-1:0]      s_cmd,
    input  logic signed [DATA_WIDTH-1:0]   s_value,
    input  logic                           q_full,
    output logic                           q_push,
    output bdq_pkg::op_ctrl_t              q_ctrl,
    output logic [$clog2(DEPTH)-1:0]       q_addr,
    output logic [$clog2(DEPTH+1)-1:0]     q_count,
    output logic [DATA_WIDTH-1:0]          q_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [PTR_W-1:0] front_idx_reg, front_idx_next;
    logic [CNT_W-1:0] count_reg, count_next;

    logic             accept;
    logic             is_full;
    logic             is_empty;
    logic [PTR_W-1:0] front_dec;
    logic [PTR_W-1:0] front_inc;
    logic [CNT_W:0]   back_sum;
    logic [CNT_W:0]   back_wrap;
    logic [PTR_W-1:0] back_addr;

    assign s_ready  = !q_full;
    assign accept   = s_valid && !q_full;
    assign is_full  = (count_reg == CNT_W'(DEPTH));
    assign is_empty = (count_reg == '0);

    assign front_dec = (front_idx_reg == '0) ? PTR_W'(DEPTH - 1) : front_idx_reg - 1'b1;
    assign front_inc = (front_idx_reg == PTR_W'(DEPTH - 1)) ? '0 : front_idx_reg + 1'b1;

    // Slot just past the back element, wrapped once around the ring.
    assign back_sum  = (CNT_W+1)'(front_idx_reg) + (CNT_W+1)'(count_reg);
    assign back_wrap = (back_sum >= (CNT_W+1)'(DEPTH)) ? back_sum - (CNT_W+1)'(DEPTH)
                                                        : back_sum;
    assign back_addr = back_wrap[PTR_W-1:0];

    always_comb begin
        front_idx_next = front_idx_reg;
        count_next     = count_reg;
        q_push         = 1'b0;
        q_ctrl.kind    = bdq_pkg::OP_STATUS;
        q_ctrl.status  = bdq_pkg::STAT_OK;
        q_addr         = front_idx_reg;
        q_count        = count_reg;
        q_data         = s_value;
        case (s_cmd)
            bdq_pkg::CMD_PUSH_FRONT: begin
                q_push = accept;
                q_addr = front_dec;
                if (is_full) begin
                    q_ctrl.status = bdq_pkg::STAT_FULL;
                end else begin
                    q_ctrl.kind = bdq_pkg::OP_WRITE;
                    if (accept) begin
                        front_idx_next = front_dec;
                        count_next     = count_reg + 1'b1;
                    end
                end
            end
            bdq_pkg::CMD_PUSH_BACK: begin
                q_push = accept;
                q_addr = back_addr;
                if (is_full) begin
                    q_ctrl.status = bdq_pkg::STAT_FULL;
                end else begin
                    q_ctrl.kind = bdq_pkg::OP_WRITE;
                    if (accept) begin
                        count_next = count_reg + 1'b1;
                    end
                end
            end
            bdq_pkg::CMD_DROP_FRONT: begin
                q_push = accept;
                if (is_empty) begin
                    q_ctrl.status = bdq_pkg::STAT_EMPTY;
                end else if (accept) begin
                    front_idx_next = front_inc;
                    count_next     = count_reg - 1'b1;
                end
            end
            bdq_pkg::CMD_DROP_BACK: begin
                q_push = accept;
                if (is_empty) begin
                    q_ctrl.status = bdq_pkg::STAT_EMPTY;
                end else if (accept) begin
                    count_next = count_reg - 1'b1;
                end
            end
            bdq_pkg::CMD_DUMP: begin
                q_push = accept;
                if (is_empty) begin
                    q_ctrl.status = bdq_pkg::STAT_EMPTY;
                end else begin
                    q_ctrl.kind = bdq_pkg::OP_DUMP;
                end
            end
            default: begin
                // Unknown commands are consumed without any effect.
                q_push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_idx_reg <= '0;
            count_reg     <= '0;
        end else begin
            front_idx_reg <= front_idx_next;
            count_reg     <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("occupancy exceeds the ring size");

    a_index_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        front_idx_reg <= PTR_W'(DEPTH - 1))
        else $error("front index outside the ring");

endmodule

// File: hdl/bdq_opq.sv
module bdq_opq #(
    parameter int DEPTH      = bdq_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = bdq_pkg::DATA_WIDTH_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       push,
    input  bdq_pkg::op_ctrl_t          push_ctrl,
    input  logic [$clog2(DEPTH)-1:0]   push_addr,
    input  logic [$clog2(DEPTH+1)-1:0] push_count,
    input  logic [DATA_WIDTH-1:0]      push_data,
    output logic                       full,
    input  logic                       pop,
    output logic                       head_valid,
    output bdq_pkg::op_ctrl_t          head_ctrl,
    output logic [$clog2(DEPTH)-1:0]   head_addr,
    output logic [$clog2(DEPTH+1)-1:0] head_count,
    output logic [DATA_WIDTH-1:0]      head_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    bdq_pkg::op_ctrl_t     ctrl_mem  [2];
    logic [PTR_W-1:0]      addr_mem  [2];
    logic [CNT_W-1:0]      count_mem [2];
    logic [DATA_WIDTH-1:0] data_mem  [2];

    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] fill_reg, fill_next;

    assign full       = (fill_reg == 2'd2);
    assign head_valid = (fill_reg != 2'd0);
    assign head_ctrl  = ctrl_mem[rd_ptr_reg];
    assign head_addr  = addr_mem[rd_ptr_reg];
    assign head_count = count_mem[rd_ptr_reg];
    assign head_data  = data_mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        fill_next   = fill_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            ctrl_mem[wr_ptr_reg]  <= push_ctrl;
            addr_mem[wr_ptr_reg]  <= push_addr;
            count_mem[wr_ptr_reg] <= push_count;
            data_mem[wr_ptr_reg]  <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !full)
        else $error("operation queue overflow");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> head_valid)
        else $error("operation queue underflow");

endmodule

// File: hdl/bdq_back.sv
module bdq_back #(
    parameter int DEPTH      = bdq_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = bdq_pkg::DATA_WIDTH_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         head_valid,
    input  bdq_pkg::op_ctrl_t            head_ctrl,
    input  logic [$clog2(DEPTH)-1:0]     head_addr,
    input  logic [$clog2(DEPTH+1)-1:0]   head_count,
    input  logic [DATA_WIDTH-1:0]        head_data,
    output logic                         pop,
    output logic                         ram_wr_en,
    output logic [$clog2(DEPTH)-1:0]     ram_wr_addr,
    output logic [DATA_WIDTH-1:0]        ram_wr_data,
    output logic                         ram_rd_en,
    output logic [$clog2(DEPTH)-1:0]     ram_rd_addr,
    input  logic [DATA_WIDTH-1:0]        ram_rd_data,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic signed [DATA_WIDTH-1:0] m_element,
    output logic                         m_last,
    output logic [bdq_pkg::STATUS_W-1:0] m_status
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic                         dump_active_reg;
    logic [PTR_W-1:0]             dump_addr_reg;
    logic [CNT_W-1:0]             dump_left_reg;
    logic                         s1_valid_reg;
    bdq_pkg::res_meta_t           s1_meta_reg;
    logic                         m_valid_reg;
    logic [DATA_WIDTH-1:0]        m_element_reg;
    logic                         m_last_reg;
    logic [bdq_pkg::STATUS_W-1:0] m_status_reg;

    logic               m_free;
    logic               s1_adv;
    logic               s1_free;
    logic               issue;
    logic               is_dump;
    logic               final_elem;
    logic [PTR_W-1:0]   cur_addr;
    logic [CNT_W-1:0]   cur_left;
    logic [PTR_W-1:0]   step_addr;
    bdq_pkg::res_meta_t issue_meta;

    // Stage one lines up with the registered RAM read; stage two is the output register.
    assign m_free  = !m_valid_reg || m_ready;
    assign s1_adv  = s1_valid_reg && m_free;
    assign s1_free = !s1_valid_reg || s1_adv;
    assign issue   = head_valid && s1_free;

    assign is_dump    = (head_ctrl.kind == bdq_pkg::OP_DUMP);
    assign cur_addr   = dump_active_reg ? dump_addr_reg : head_addr;
    assign cur_left   = dump_active_reg ? dump_left_reg : head_count;
    assign final_elem = (cur_left == CNT_W'(1));
    assign step_addr  = (cur_addr == PTR_W'(DEPTH - 1)) ? '0 : cur_addr + 1'b1;

    // A dump stays at the head of the queue until its final element is issued.
    assign pop = issue && (!is_dump || final_elem);

    assign ram_wr_en   = issue && (head_ctrl.kind == bdq_pkg::OP_WRITE);
    assign ram_wr_addr = head_addr;
    assign ram_wr_data = head_data;
    assign ram_rd_en   = issue && is_dump;
    assign ram_rd_addr = cur_addr;

    always_comb begin
        issue_meta.dump   = is_dump;
        issue_meta.last   = !is_dump || final_elem;
        issue_meta.status = head_ctrl.status;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dump_active_reg <= 1'b0;
            s1_valid_reg    <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (issue && is_dump) begin
                dump_active_reg <= !final_elem;
            end
            if (s1_free) begin
                s1_valid_reg <= issue;
            end
            if (m_free) begin
                m_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (issue && is_dump) begin
            dump_addr_reg <= step_addr;
            dump_left_reg <= cur_left - 1'b1;
        end
        if (issue) begin
            s1_meta_reg <= issue_meta;
        end
        if (s1_adv) begin
            m_element_reg <= s1_meta_reg.dump ? ram_rd_data : '0;
            m_last_reg    <= s1_meta_reg.last;
            m_status_reg  <= s1_meta_reg.status;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_element = m_element_reg;
    assign m_last    = m_last_reg;
    assign m_status  = m_status_reg;

    a_dump_holds_head: assert property (@(posedge aclk) disable iff (!aresetn)
        dump_active_reg |-> head_valid && (head_ctrl.kind == bdq_pkg::OP_DUMP))
        else $error("dump in progress without its command at the queue head");

    a_multi_only_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_last) |-> (m_status == bdq_pkg::STAT_OK))
        else $error("non-final result carries an error status");

endmodule

// File: hdl/bounded_double_ended_queue.sv
// A command's first result passes through the operation queue, stage one and the output register.
// Throughput: one command per cycle while the operation queue is not full; push and drop give one result each.
// A dump of N elements holds the back end until all N are issued, one RAM read per element.
// Reset (synchronous, active low) empties the queue; store contents are not cleared.
// The two-entry operation queue between front and back sets s_ready.
module bounded_double_ended_queue #(
    parameter int DEPTH      = bdq_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = bdq_pkg::DATA_WIDTH_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [bdq_pkg::CMD_W-1:0]    s_cmd,
    input  logic signed [DATA_WIDTH-1:0] s_value,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic signed [DATA_WIDTH-1:0] m_element,
    output logic                         m_last,
    output logic [bdq_pkg::STATUS_W-1:0] m_status
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic                  q_full;
    logic                  q_push;
    bdq_pkg::op_ctrl_t     q_ctrl;
    logic [PTR_W-1:0]      q_addr;
    logic [CNT_W-1:0]      q_count;
    logic [DATA_WIDTH-1:0] q_data;

    logic                  q_pop;
    logic                  head_valid;
    bdq_pkg::op_ctrl_t     head_ctrl;
    logic [PTR_W-1:0]      head_addr;
    logic [CNT_W-1:0]      head_count;
    logic [DATA_WIDTH-1:0] head_data;

    logic                  ram_wr_en;
    logic [PTR_W-1:0]      ram_wr_addr;
    logic [DATA_WIDTH-1:0] ram_wr_data;
    logic                  ram_rd_en;
    logic [PTR_W-1:0]      ram_rd_addr;
    logic [DATA_WIDTH-1:0] ram_rd_data;

    bdq_front #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_cmd   (s_cmd),
        .s_value (s_value),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_ctrl  (q_ctrl),
        .q_addr  (q_addr),
        .q_count (q_count),
        .q_data  (q_data)
    );

    bdq_opq #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_opq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_ctrl  (q_ctrl),
        .push_addr  (q_addr),
        .push_count (q_count),
        .push_data  (q_data),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (head_valid),
        .head_ctrl  (head_ctrl),
        .head_addr  (head_addr),
        .head_count (head_count),
        .head_data  (head_data)
    );

    bdq_back #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .head_valid  (head_valid),
        .head_ctrl   (head_ctrl),
        .head_addr   (head_addr),
        .head_count  (head_count),
        .head_data   (head_data),
        .pop         (q_pop),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data),
        .ram_rd_en   (ram_rd_en),
        .ram_rd_addr (ram_rd_addr),
        .ram_rd_data (ram_rd_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_element   (m_element),
        .m_last      (m_last),
        .m_status    (m_status)
    );

    bdq_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

endmodule

// File: test/tb_bounded_double_ended_queue.sv
`timescale 1ns / 1ps

module tb_bounded_double_ended_queue;

    localparam int DEPTH = bdq_pkg::DEPTH_DEF;
    localparam int DW    = bdq_pkg::DATA_WIDTH_DEF;
    localparam int IDX_W = $clog2(DEPTH);

    localparam logic [bdq_pkg::CMD_W-1:0] CMD_RSVD_LO  = 3'd5;
    localparam logic [bdq_pkg::CMD_W-1:0] CMD_RSVD_MID = 3'd6;
    localparam logic [bdq_pkg::CMD_W-1:0] CMD_RSVD_HI  = 3'd7;

    localparam int RANDOM_ITEMS = 180;
    localparam int SETTLE_CYCLES = 16;

    typedef struct packed {
        logic signed [DW-1:0]         element;
        logic                         last;
        logic [bdq_pkg::STATUS_W-1:0] status;
    } deque_result_t;

    typedef struct packed {
        logic [bdq_pkg::CMD_W-1:0] cmd;
        logic [DW-1:0]             value;
        logic                      typed;
        deque_result_t             want;
    } stim_row_t;

    localparam deque_result_t RES_OK    = '{'0, 1'b1, bdq_pkg::STAT_OK};
    localparam deque_result_t RES_EMPTY = '{'0, 1'b1, bdq_pkg::STAT_EMPTY};
    localparam deque_result_t NO_RES    = '0;

    localparam int DIR_ROWS = 22;

    // Rows whose result is obvious carry it; the rest rely on the deque model.
    stim_row_t dir_rows [DIR_ROWS] = '{
        '{bdq_pkg::CMD_DUMP,       32'h0000_0000, 1'b1, RES_EMPTY},
        '{bdq_pkg::CMD_DROP_FRONT, 32'h0000_0000, 1'b1, RES_EMPTY},
        '{bdq_pkg::CMD_DROP_BACK,  32'hdead_beef, 1'b1, RES_EMPTY},
        '{CMD_RSVD_LO,             32'h1234_5678, 1'b0, NO_RES},
        '{bdq_pkg::CMD_PUSH_BACK,  32'h7fff_ffff, 1'b1, RES_OK},
        '{bdq_pkg::CMD_PUSH_FRONT, 32'h8000_0000, 1'b1, RES_OK},
        '{bdq_pkg::CMD_PUSH_BACK,  32'hffff_ffff, 1'b1, RES_OK},
        '{bdq_pkg::CMD_PUSH_FRONT, 32'h0000_0000, 1'b1, RES_OK},
        '{bdq_pkg::CMD_PUSH_BACK,  32'h0000_0001, 1'b1, RES_OK},
        '{bdq_pkg::CMD_DUMP,       32'hffff_ffff, 1'b0, NO_RES},
        '{bdq_pkg::CMD_DROP_FRONT, 32'h0000_0000, 1'b1, RES_OK},
        '{bdq_pkg::CMD_DROP_BACK,  32'h0000_0000, 1'b1, RES_OK},
        '{CMD_RSVD_MID,            32'hffff_ffff, 1'b0, NO_RES},
        '{bdq_pkg::CMD_DUMP,       32'h0000_0000, 1'b0, NO_RES},
        '{bdq_pkg::CMD_DROP_FRONT, 32'h0000_0000, 1'b1, RES_OK},
        '{bdq_pkg::CMD_DROP_BACK,  32'h0000_0000, 1'b1, RES_OK},
        '{bdq_pkg::CMD_DROP_BACK,  32'h0000_0000, 1'b1, RES_OK},
        '{bdq_pkg::CMD_DUMP,       32'h0000_0000, 1'b1, RES_EMPTY},
        '{CMD_RSVD_HI,             32'h5555_aaaa, 1'b0, NO_RES},
        '{bdq_pkg::CMD_PUSH_FRONT, 32'h5a5a_5a5a, 1'b1, RES_OK},
        '{bdq_pkg::CMD_DUMP,       32'h0000_0000, 1'b0, NO_RES},
        '{bdq_pkg::CMD_DROP_FRONT, 32'h0000_0000, 1'b1, RES_OK}
    };

    logic                         aclk = 1'b0;
    logic                         aresetn;
    logic                         s_valid;
    logic                         s_ready;
    logic [bdq_pkg::CMD_W-1:0]    s_cmd;
    logic signed [DW-1:0]         s_value;
    logic                         m_valid;
    logic                         m_ready;
    logic signed [DW-1:0]         m_element;
    logic                         m_last;
    logic [bdq_pkg::STATUS_W-1:0] m_status;

    // Shadow copy of the deque contents.
    logic [DW-1:0]    ring [DEPTH];
    logic [IDX_W-1:0] ring_head;
    int               held;

    deque_result_t pending_results [$];
    int            mismatches;
    int            accepted_cmds;
    bit            tx_idle_on;
    bit            rx_idle_on;
    int            rx_stall_left;

    bounded_double_ended_queue dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_cmd     (s_cmd),
        .s_value   (s_value),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_element (m_element),
        .m_last    (m_last),
        .m_status  (m_status)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [DW-1:0] pick_value();
        if ($urandom_range(0, 9) != 0) return $urandom;
        case ($urandom_range(0, 3))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return 32'hffff_ffff;
            default: return '0;
        endcase
    endfunction

    function automatic void add_result(logic [DW-1:0] element, logic last,
                                       logic [bdq_pkg::STATUS_W-1:0] status);
        deque_result_t r;
        r.element = element;
        r.last    = last;
        r.status  = status;
        pending_results.push_back(r);
    endfunction

    // Applies one command to the shadow deque and queues the results it yields.
    function automatic void predict_deque_op(logic [bdq_pkg::CMD_W-1:0] cmd,
                                             logic [DW-1:0] value);
        logic [IDX_W-1:0] slot;
        case (cmd)
            bdq_pkg::CMD_PUSH_FRONT, bdq_pkg::CMD_PUSH_BACK: begin
                if (held >= DEPTH) begin
                    add_result('0, 1'b1, bdq_pkg::STAT_FULL);
                end else begin
                    if (cmd == bdq_pkg::CMD_PUSH_FRONT) begin
                        ring_head = ring_head - 1'b1;
                        slot = ring_head;
                    end else begin
                        slot = ring_head + IDX_W'(held);
                    end
                    ring[slot] = value;
                    held++;
                    add_result('0, 1'b1, bdq_pkg::STAT_OK);
                end
            end
            bdq_pkg::CMD_DROP_FRONT, bdq_pkg::CMD_DROP_BACK: begin
                if (held == 0) begin
                    add_result('0, 1'b1, bdq_pkg::STAT_EMPTY);
                end else begin
                    if (cmd == bdq_pkg::CMD_DROP_FRONT) ring_head = ring_head + 1'b1;
                    held--;
                    add_result('0, 1'b1, bdq_pkg::STAT_OK);
                end
            end
            bdq_pkg::CMD_DUMP: begin
                if (held == 0) begin
                    add_result('0, 1'b1, bdq_pkg::STAT_EMPTY);
                end else begin
                    for (int i = 0; i < held; i++) begin
                        slot = ring_head + IDX_W'(i);
                        add_result(ring[slot], i == held - 1, bdq_pkg::STAT_OK);
                    end
                end
            end
            default: ;
        endcase
    endfunction

    // Presents one command, holds it until the transaction completes, then predicts it.
    task automatic send_cmd(input logic [bdq_pkg::CMD_W-1:0] cmd,
                            input logic [DW-1:0] value,
                            input logic typed, input deque_result_t want);
        int gap;
        gap = tx_idle_on ? pick_gap() : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_cmd   <= cmd;
        s_value <= value;
        do @(posedge aclk); while (!s_ready);
        predict_deque_op(cmd, value);
        if (typed) begin
            void'(pending_results.pop_back());
            pending_results.push_back(want);
        end
        accepted_cmds++;
    endtask

    task automatic send_random_cmd();
        int r;
        logic [bdq_pkg::CMD_W-1:0] cmd;
        r = $urandom_range(0, 99);
        if (r < 25)      cmd = bdq_pkg::CMD_PUSH_FRONT;
        else if (r < 50) cmd = bdq_pkg::CMD_PUSH_BACK;
        else if (r < 65) cmd = bdq_pkg::CMD_DROP_FRONT;
        else if (r < 80) cmd = bdq_pkg::CMD_DROP_BACK;
        else if (r < 94) cmd = bdq_pkg::CMD_DUMP;
        else cmd = bdq_pkg::CMD_W'($urandom_range(CMD_RSVD_LO, CMD_RSVD_HI));
        send_cmd(cmd, pick_value(), 1'b0, NO_RES);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        wait (pending_results.size() == 0);
        @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        if (rx_stall_left > 0) begin
            m_ready <= 1'b0;
            rx_stall_left = rx_stall_left - 1;
        end else begin
            m_ready <= 1'b1;
            if (rx_idle_on) rx_stall_left = pick_gap();
        end
    end

    always @(posedge aclk) begin
        deque_result_t want;
        if (aresetn === 1'b1 && m_valid === 1'b1 && m_ready === 1'b1) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected transaction: element %0d last %0b status %0d",
                         $time, m_element, m_last, m_status);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                if (m_element !== want.element) begin
                    $display("%0t: element mismatch: expected %0d, actual %0d",
                             $time, want.element, m_element);
                    mismatches++;
                end
                if (m_last !== want.last) begin
                    $display("%0t: last mismatch: expected %0b, actual %0b",
                             $time, want.last, m_last);
                    mismatches++;
                end
                if (m_status !== want.status) begin
                    $display("%0t: status mismatch: expected %0d, actual %0d",
                             $time, want.status, m_status);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        #20_000_000;
        $display("Timeout with %0d results outstanding", pending_results.size());
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        int kind;
        int burst;
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_cmd         = bdq_pkg::CMD_PUSH_FRONT;
        s_value       = '0;
        m_ready       = 1'b0;
        ring_head     = '0;
        held          = 0;
        mismatches    = 0;
        accepted_cmds = 0;
        tx_idle_on    = 1'b1;
        rx_idle_on    = 1'b1;
        rx_stall_left = 0;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (dir_rows[i])
            send_cmd(dir_rows[i].cmd, dir_rows[i].value, dir_rows[i].typed, dir_rows[i].want);
        wait_drained();

        // A stretch at full rate on both sides.
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        repeat (20) send_random_cmd();

        // Fill to capacity, try to overflow, read everything back, then hold off.
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        while (held < DEPTH)
            send_cmd($urandom_range(0, 1) ? bdq_pkg::CMD_PUSH_FRONT : bdq_pkg::CMD_PUSH_BACK,
                     pick_value(), 1'b0, NO_RES);
        send_cmd(bdq_pkg::CMD_PUSH_BACK, pick_value(), 1'b0, NO_RES);
        send_cmd(bdq_pkg::CMD_PUSH_FRONT, pick_value(), 1'b0, NO_RES);
        send_cmd(bdq_pkg::CMD_DUMP, '0, 1'b0, NO_RES);
        wait_drained();

        while (accepted_cmds < RANDOM_ITEMS) begin
            kind = $urandom_range(0, 9);
            if (kind < 6) begin
                burst = $urandom_range(10, 25);
                repeat (burst) send_random_cmd();
            end else if (kind < 8) begin
                // Drain from either end until empty, then one drop too many and a dump.
                while (held > 0)
                    send_cmd($urandom_range(0, 1) ? bdq_pkg::CMD_DROP_FRONT
                                                  : bdq_pkg::CMD_DROP_BACK,
                             pick_value(), 1'b0, NO_RES);
                send_cmd($urandom_range(0, 1) ? bdq_pkg::CMD_DROP_FRONT
                                              : bdq_pkg::CMD_DROP_BACK,
                         pick_value(), 1'b0, NO_RES);
                send_cmd(bdq_pkg::CMD_DUMP, pick_value(), 1'b0, NO_RES);
            end else begin
                tx_idle_on = $urandom_range(0, 1);
                rx_idle_on = $urandom_range(0, 1);
            end
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
